### hdl/trimmed_mean_jump_reset_smoother_unit_defines.svh
`ifndef TRIMMED_MEAN_JUMP_RESET_SMOOTHER_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_JUMP_RESET_SMOOTHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TMJRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TMJRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tmjrs_pkg.sv
`default_nettype none

package tmjrs_pkg;

  localparam int SampleW  = 12;
  localparam int SumW     = 16;
  localparam int AccW     = 18;
  localparam int CntW     = 4;
  localparam int BatchLen = 10;
  localparam int TrimDiv  = 8;
  localparam int Coe      = 8;
  localparam int ThrReset = 60;

  localparam logic [CntW-1:0]    LastIdx   = CntW'(BatchLen - 1);
  localparam logic [SampleW-1:0] SampleMax = '1;
  localparam logic [SumW-1:0]    TrimDivS  = SumW'(TrimDiv);
  localparam logic [AccW-1:0]    CoeA      = AccW'(Coe);
  localparam logic [AccW-1:0]    AccMax    = AccW'(Coe * 4096 - 1);
  localparam logic [SampleW-1:0] ThrInit   = SampleW'(ThrReset);

  // Statistics of one finished batch, handed from the collector to the averager.
  typedef struct packed {
    logic               valid;
    logic [SumW-1:0]    sum;
    logic [SampleW-1:0] max;
    logic [SampleW-1:0] min;
  } tmjrs_batch_t;

endpackage

`default_nettype wire

### hdl/tmjrs_in_if.sv
`default_nettype none

interface tmjrs_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmjrs_pkg::SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### hdl/tmjrs_out_if.sv
`default_nettype none

interface tmjrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [tmjrs_pkg::SampleW-1:0] smoothed;
  logic [tmjrs_pkg::SampleW-1:0] trimmed_mean;

  modport source (output valid, output smoothed, output trimmed_mean, input ready);
  modport sink   (input valid, input smoothed, input trimmed_mean, output ready);
endinterface

`default_nettype wire

### hdl/tmjrs_cfg_if.sv
`default_nettype none

interface tmjrs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tmjrs_pkg::SampleW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/trimmed_mean_jump_reset_smoother_unit.sv
// Trimmed-mean smoother for 12-bit converter samples. One sample is taken per clock while
// in_ch.ready is high; every tenth sample closes a batch, whose sum less its largest and
// smallest sample, divided by eight, is the trimmed mean. That mean drives a moving average
// held as eight times the average: the first batch after reset loads it, a mean further than
// the threshold from the average reloads it, and otherwise it moves by mean minus average.
// One transaction per batch carries smoothed and trimmed_mean, registered first in the batch
// register and then in the result register. in_ch.ready drops only while a finished batch
// waits behind a result that the sink has not taken. The threshold (reset 60) is written
// over the cfg channel, which is always ready, and should change only while idle.
`default_nettype none

module trimmed_mean_jump_reset_smoother_unit (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tmjrs_in_if.sink      in_ch,
  tmjrs_cfg_if.sink     cfg_ch,
  tmjrs_out_if.source   out_ch
);

  tmjrs_pkg::tmjrs_batch_t done;
  logic                    done_ready;

  tmjrs_batch u_batch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .done       (done),
    .done_ready (done_ready)
  );

  tmjrs_avg u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .done_ready (done_ready),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### hdl/tmjrs_batch.sv
`default_nettype none

`include "trimmed_mean_jump_reset_smoother_unit_defines.svh"

module tmjrs_batch (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  tmjrs_in_if.sink                     in_ch,
  output tmjrs_pkg::tmjrs_batch_t      done,
  input  wire logic                    done_ready
);

  logic [tmjrs_pkg::CntW-1:0]    count_r, count_nxt;
  logic [tmjrs_pkg::SumW-1:0]    sum_r, sum_nxt, sum_acc;
  logic [tmjrs_pkg::SampleW-1:0] max_r, max_nxt, max_acc;
  logic [tmjrs_pkg::SampleW-1:0] min_r, min_nxt, min_acc;
  tmjrs_pkg::tmjrs_batch_t       done_r, done_nxt;
  logic                          accept;
  logic                          last;

  assign in_ch.ready = !done_r.valid || done_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last        = (count_r == tmjrs_pkg::LastIdx);
  assign done        = done_r;

  always_comb begin
    sum_acc = sum_r + tmjrs_pkg::SumW'(in_ch.sample);
    max_acc = (in_ch.sample > max_r) ? in_ch.sample : max_r;
    min_acc = (in_ch.sample < min_r) ? in_ch.sample : min_r;

    count_nxt = count_r;
    sum_nxt   = sum_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    done_nxt  = done_r;

    if (done_ready) begin
      done_nxt.valid = 1'b0;
    end

    if (accept) begin
      if (last) begin
        // Hand the finished batch on and start a fresh one.
        done_nxt.valid = 1'b1;
        done_nxt.sum   = sum_acc;
        done_nxt.max   = max_acc;
        done_nxt.min   = min_acc;
        count_nxt      = '0;
        sum_nxt        = '0;
        max_nxt        = '0;
        min_nxt        = tmjrs_pkg::SampleMax;
      end else begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_acc;
        max_nxt   = max_acc;
        min_nxt   = min_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      max_r   <= '0;
      min_r   <= tmjrs_pkg::SampleMax;
      done_r  <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      done_r  <= done_nxt;
    end
  end

  `TMJRS_ASSERT_NOW(a_count_range, 1'b1, count_r <= tmjrs_pkg::LastIdx,
    "batch count ran past the batch length")
  `TMJRS_ASSERT_NEXT(a_batch_done, accept && last, done_r.valid && count_r == '0,
    "tenth sample did not close the batch")
  `TMJRS_ASSERT_NOW(a_extremes, count_r != '0, max_r >= min_r,
    "batch maximum below batch minimum")

endmodule

`default_nettype wire

### hdl/tmjrs_avg.sv
`default_nettype none

`include "trimmed_mean_jump_reset_smoother_unit_defines.svh"

module tmjrs_avg (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  tmjrs_pkg::tmjrs_batch_t      done,
  output logic                         done_ready,
  tmjrs_cfg_if.sink                    cfg_ch,
  tmjrs_out_if.source                  out_ch
);

  logic [tmjrs_pkg::SampleW-1:0] thr_r, thr_nxt;
  logic [tmjrs_pkg::AccW-1:0]    acc_r, acc_nxt;
  logic                          primed_r, primed_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [tmjrs_pkg::SampleW-1:0] smoothed_r, smoothed_nxt;
  logic [tmjrs_pkg::SampleW-1:0] mean_r, mean_nxt;

  logic [tmjrs_pkg::SumW-1:0]    trim;
  logic [tmjrs_pkg::SampleW-1:0] mean;
  logic [tmjrs_pkg::AccW-1:0]    avg_full;
  logic [tmjrs_pkg::SampleW-1:0] avg;
  logic [tmjrs_pkg::SampleW-1:0] diff;
  logic [tmjrs_pkg::AccW-1:0]    acc_load;
  logic [tmjrs_pkg::AccW-1:0]    acc_move;
  logic [tmjrs_pkg::AccW-1:0]    acc_new;
  logic [tmjrs_pkg::AccW-1:0]    smooth_full;
  logic                          take;

  assign cfg_ch.ready = 1'b1;
  assign done_ready   = !out_valid_r || out_ch.ready;
  assign take         = done.valid && done_ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.smoothed     = smoothed_r;
  assign out_ch.trimmed_mean = mean_r;

  always_comb begin
    // Drop one copy of each extreme; the rest stays below 2^15.
    trim     = done.sum - tmjrs_pkg::SumW'(done.max) - tmjrs_pkg::SumW'(done.min);
    mean     = tmjrs_pkg::SampleW'(trim / tmjrs_pkg::TrimDivS);
    avg_full = acc_r / tmjrs_pkg::CoeA;
    avg      = avg_full[tmjrs_pkg::SampleW-1:0];
    diff     = (mean > avg) ? (mean - avg) : (avg - mean);
    acc_load = tmjrs_pkg::AccW'(mean) * tmjrs_pkg::CoeA;
    acc_move = acc_r + tmjrs_pkg::AccW'(mean) - tmjrs_pkg::AccW'(avg);
    acc_new  = (!primed_r || diff > thr_r) ? acc_load : acc_move;
    smooth_full = acc_new / tmjrs_pkg::CoeA;

    thr_nxt       = (cfg_ch.valid) ? cfg_ch.data : thr_r;
    acc_nxt       = acc_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r;
    smoothed_nxt  = smoothed_r;
    mean_nxt      = mean_r;

    if (take) begin
      acc_nxt       = acc_new;
      primed_nxt    = 1'b1;
      out_valid_nxt = 1'b1;
      smoothed_nxt  = smooth_full[tmjrs_pkg::SampleW-1:0];
      mean_nxt      = mean;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= tmjrs_pkg::ThrInit;
      acc_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      acc_r       <= acc_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smoothed_r <= smoothed_nxt;
    mean_r     <= mean_nxt;
  end

  `TMJRS_ASSERT_NOW(a_acc_range, 1'b1, acc_r <= tmjrs_pkg::AccMax,
    "average accumulator out of range")
  `TMJRS_ASSERT_NEXT(a_first_load, take && !primed_r,
    primed_r && out_valid_r && smoothed_r == mean_r,
    "first batch did not load the average from its mean")

endmodule

`default_nettype wire
